@@ rtl/core/mbrf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrf_pkg: shared types and constants of the register framer
// Request codes, command entries passed from front to back, frame constants
// and the byte-wise CRC-16 update.
// ----------------------------------------------------------------------------
package mbrf_pkg;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_RX    = 2'd2
  } req_t;

  typedef enum logic {
    KIND_TX    = 1'b0,
    KIND_VALUE = 1'b1
  } kind_t;

  localparam logic [7:0]  FUNC_READ    = 8'h03;
  localparam logic [7:0]  FUNC_WRITE   = 8'h06;
  localparam logic [15:0] READ_COUNT   = 16'h0001;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [7:0]  SLAVE_RESET  = 8'h01;
  localparam logic [2:0]  HI_POS_READ  = 3'd3;
  localparam logic [2:0]  HI_POS_WRITE = 3'd4;
  localparam logic [2:0]  IDX_MAX      = 3'd7;
  localparam logic [2:0]  LAST_BYTE    = 3'd7;
  localparam logic [2:0]  CRC_LO_BYTE  = 3'd6;
  localparam int          QDEPTH       = 2;
  localparam int          QPTR_W       = $clog2(QDEPTH);
  localparam int          QCNT_W       = $clog2(QDEPTH + 1);

  // One unit of work for the back end: a frame to send or a value to report.
  // For a value, addr is the pending register and word the decoded data.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [15:0] addr;
    logic [15:0] word;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/mbrf_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrf_front: request intake and reply byte tracking
// Records the pending command, counts reply bytes, assembles the data word
// and pushes frame or value commands into the queue.
// ----------------------------------------------------------------------------
module mbrf_front import mbrf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [7:0]         cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic [15:0]        reg_addr,
  input  wire logic signed [15:0] write_value,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               rx_first,
  input  wire q_stat_t            q_stat,
  output logic                    push,
  output cmd_t                    push_cmd
);

  logic [7:0]  slave_address;
  logic        pending_is_write;
  logic [15:0] pending_register;
  logic [2:0]  reply_byte_index;
  logic [7:0]  reply_high_byte;

  logic        accept;
  logic [2:0]  hi_pos;
  logic [2:0]  idx;
  logic        is_req;
  logic        is_rx;
  logic        take_high;
  logic        emit_value;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign hi_pos   = pending_is_write ? HI_POS_WRITE : HI_POS_READ;
  assign idx      = rx_first ? 3'd0 : reply_byte_index;

  always_comb begin
    is_req = 1'b0;
    is_rx  = 1'b0;
    unique case (req_type)
      REQ_READ, REQ_WRITE: is_req = 1'b1;
      REQ_RX:              is_rx  = 1'b1;
      default:             ;
    endcase
  end

  assign take_high  = is_rx && (idx == hi_pos);
  assign emit_value = is_rx && (idx == hi_pos + 3'd1);
  assign push       = accept && (is_req || emit_value);

  always_comb begin
    push_cmd.slave = slave_address;
    if (is_req) begin
      push_cmd.kind = KIND_TX;
      push_cmd.func = (req_type == REQ_WRITE) ? FUNC_WRITE : FUNC_READ;
      push_cmd.addr = reg_addr;
      push_cmd.word = (req_type == REQ_WRITE) ? write_value : READ_COUNT;
    end else begin
      push_cmd.kind = KIND_VALUE;
      push_cmd.func = 8'h00;
      push_cmd.addr = pending_register;
      push_cmd.word = {reply_high_byte, rx_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address    <= SLAVE_RESET;
      pending_is_write <= 1'b0;
      pending_register <= 16'h0000;
      reply_byte_index <= 3'd0;
      reply_high_byte  <= 8'h00;
    end else begin
      if (cfg_wr_en) begin
        slave_address <= cfg_wr_data;
      end
      if (accept && is_req) begin
        pending_is_write <= (req_type == REQ_WRITE);
        pending_register <= reg_addr;
      end
      if (accept && is_rx) begin
        // saturate so a long reply reports at most one value
        reply_byte_index <= (idx < IDX_MAX) ? idx + 3'd1 : IDX_MAX;
        if (take_high) begin
          reply_high_byte <= rx_byte;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/mbrf_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrf_queue: command queue between front and back
// Small FIFO of command entries; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module mbrf_queue import mbrf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output q_stat_t   q_stat
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head         = mem[rd_ptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/mbrf_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrf_back: frame serializer and result output register
// Sends frame bytes one per beat while folding them into the CRC, then the
// CRC low and high bytes; value commands go out as one beat.
// ----------------------------------------------------------------------------
module mbrf_back import mbrf_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cmd_t         head,
  input  wire q_stat_t      q_stat,
  output logic              pop,
  output logic              mid_frame,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic              out_kind,
  output logic [7:0]        tx_byte,
  output logic              tx_last,
  output logic [15:0]       reply_addr,
  output logic signed [15:0] reply_value
);

  logic [2:0]  cnt;
  logic [15:0] crc;
  logic [15:0] crc_in;
  logic [7:0]  byte_sel;
  logic        advance;
  logic        work;
  logic        is_frame;

  assign advance   = !out_valid || !out_stall;
  assign work      = advance && !q_stat.empty;
  assign is_frame  = (head.kind == KIND_TX);
  assign pop       = work && (!is_frame || cnt == LAST_BYTE);
  assign mid_frame = (cnt != 3'd0);
  assign crc_in    = (cnt == 3'd0) ? CRC_INIT : crc;

  always_comb begin
    unique case (cnt)
      3'd0:    byte_sel = head.slave;
      3'd1:    byte_sel = head.func;
      3'd2:    byte_sel = head.addr[15:8];
      3'd3:    byte_sel = head.addr[7:0];
      3'd4:    byte_sel = head.word[15:8];
      3'd5:    byte_sel = head.word[7:0];
      3'd6:    byte_sel = crc[7:0];
      default: byte_sel = crc[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= 3'd0;
    end else if (advance) begin
      out_valid <= !q_stat.empty;
      if (work && is_frame) begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (work && is_frame && cnt < CRC_LO_BYTE) begin
      crc <= crc_update(crc_in, byte_sel);
    end
    if (work) begin
      if (is_frame) begin
        out_kind    <= KIND_TX;
        tx_byte     <= byte_sel;
        tx_last     <= (cnt == LAST_BYTE);
        reply_addr  <= 16'h0000;
        reply_value <= 16'sh0000;
      end else begin
        out_kind    <= KIND_VALUE;
        tx_byte     <= 8'h00;
        tx_last     <= 1'b0;
        reply_addr  <= head.addr;
        reply_value <= head.word;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/modbus_rtu_register_framer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Path: each accepted request or reply value is registered in the queue and
//   then in the output register before out_valid rises.
// Throughput: a request yields 8 frame bytes, the first six folded into the
//   CRC in the serializer; reply bytes are taken one per cycle unless in_stall.
// Reset: rst is synchronous; clears queue, counters and pending state and
//   sets the slave address to 1.
// ----------------------------------------------------------------------------
// modbus_rtu_register_framer: single holding register master framer
// Front end tracks requests and replies, back end serializes frames with
// CRC-16 and presents decoded reply values.
// ----------------------------------------------------------------------------
module modbus_rtu_register_framer import mbrf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [7:0]         cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic [15:0]        reg_addr,
  input  wire logic signed [15:0] write_value,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               rx_first,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_kind,
  output logic [7:0]              tx_byte,
  output logic                    tx_last,
  output logic [15:0]             reply_addr,
  output logic signed [15:0]      reply_value
);

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    head;
  logic    push;
  logic    pop;
  logic    mid_frame;

  mbrf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .reg_addr    (reg_addr),
    .write_value (write_value),
    .rx_byte     (rx_byte),
    .rx_first    (rx_first),
    .q_stat      (q_stat),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  mbrf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  mbrf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .mid_frame   (mid_frame),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .tx_byte     (tx_byte),
    .tx_last     (tx_last),
    .reply_addr  (reply_addr),
    .reply_value (reply_value)
  );

  // a frame in progress keeps its command at the queue head
  a_frame_holds_head: assert property (@(posedge clk) disable iff (rst)
    mid_frame |-> (!q_stat.empty && head.kind == KIND_TX))
    else $error("frame in progress without a frame command at queue head");

  a_queue_consistent: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.empty && q_stat.full))
    else $error("queue reports empty and full");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("push into a full queue");

  // while the last frame byte is presented the byte counter is back at zero
  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_TX && tx_last) |-> !mid_frame)
    else $error("frame counter not cleared after last byte");

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: Modbus RTU single register framer
// Drives read and write requests and reply bytes through the valid/stall
// input channel. A local predictor builds each expected frame byte,
// including the CRC-16, and each decoded reply value. A checker compares
// every output beat with the oldest expected beat.
// ----------------------------------------------------------------------------
module testbench;
  import mbrf_pkg::*;

  localparam logic [1:0] REQ_UNUSED    = 2'd3;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         STUCK_LIMIT   = 2000;
  localparam int         SETTLE_CYCLES = 10;

  typedef struct {
    kind_t       kind;
    logic [7:0]  tx;
    logic        last;
    logic [15:0] addr;
    logic [15:0] value;
  } out_beat_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_wr_en   = 1'b0;
  logic [7:0]         cfg_wr_data = 8'h00;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [1:0]         req_type    = 2'd0;
  logic [15:0]        reg_addr    = 16'h0000;
  logic signed [15:0] write_value = 16'sh0000;
  logic [7:0]         rx_byte     = 8'h00;
  logic               rx_first    = 1'b0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic               out_kind;
  logic [7:0]         tx_byte;
  logic               tx_last;
  logic [15:0]        reply_addr;
  logic signed [15:0] reply_value;

  // predictor state
  logic [7:0]  m_slave      = SLAVE_RESET;
  logic        m_pend_write = 1'b0;
  logic [15:0] m_pend_reg   = 16'h0000;
  logic [2:0]  m_rx_idx     = 3'd0;
  logic [7:0]  m_rx_hi      = 8'h00;

  out_beat_t due_beats[$];
  int        n_errors  = 0;
  bit        calm      = 1'b0;
  int        hold_reqs = 0;
  int        hold_seen = 0;
  int        hold_left = 0;
  int        stuck     = 0;

  modbus_rtu_register_framer u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .reg_addr    (reg_addr),
    .write_value (write_value),
    .rx_byte     (rx_byte),
    .rx_first    (rx_first),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .tx_byte     (tx_byte),
    .tx_last     (tx_last),
    .reply_addr  (reply_addr),
    .reply_value (reply_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // LSB-first bit-serial form of CRC-16/MODBUS
  function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
                                                    input logic [7:0]  data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic predict_framer(input logic [1:0] req, input logic [15:0] addr,
                                input logic [15:0] value, input logic [7:0] rxb,
                                input logic first);
    logic [7:0]  frame [8];
    logic [15:0] crc;
    logic [15:0] word;
    logic [2:0]  hi_pos;
    out_beat_t   beat;
    if (req == REQ_READ || req == REQ_WRITE) begin
      word         = (req == REQ_WRITE) ? value : READ_COUNT;
      m_pend_write = (req == REQ_WRITE);
      m_pend_reg   = addr;
      frame[0]     = m_slave;
      frame[1]     = (req == REQ_WRITE) ? FUNC_WRITE : FUNC_READ;
      frame[2]     = addr[15:8];
      frame[3]     = addr[7:0];
      frame[4]     = word[15:8];
      frame[5]     = word[7:0];
      crc = CRC_INIT;
      for (int i = 0; i < 6; i++) begin
        crc = crc16_modbus_byte(crc, frame[i]);
      end
      frame[6] = crc[7:0];
      frame[7] = crc[15:8];
      for (int i = 0; i < 8; i++) begin
        beat.kind  = KIND_TX;
        beat.tx    = frame[i];
        beat.last  = (i == 7);
        beat.addr  = 16'h0000;
        beat.value = 16'h0000;
        due_beats.push_back(beat);
      end
    end else if (req == REQ_RX) begin
      if (first) begin
        m_rx_idx = 3'd0;
      end
      hi_pos = m_pend_write ? HI_POS_WRITE : HI_POS_READ;
      if (m_rx_idx == hi_pos) begin
        m_rx_hi = rxb;
      end else if (m_rx_idx == hi_pos + 3'd1) begin
        beat.kind  = KIND_VALUE;
        beat.tx    = 8'h00;
        beat.last  = 1'b0;
        beat.addr  = m_pend_reg;
        beat.value = {m_rx_hi, rxb};
        due_beats.push_back(beat);
      end
      // saturate: bytes past the end of a long reply are dropped
      if (m_rx_idx < IDX_MAX) begin
        m_rx_idx = m_rx_idx + 3'd1;
      end
    end
  endtask

  // Offer one beat, hold it until taken, then predict its results.
  task automatic send_item(input logic [1:0] req, input logic [15:0] addr,
                           input logic [15:0] value, input logic [7:0] rxb,
                           input logic first);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    reg_addr    <= addr;
    write_value <= value;
    rx_byte     <= rxb;
    rx_first    <= first;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_framer(req, addr, value, rxb, first);
  endtask

  task automatic send_request(input req_t req, input logic [15:0] addr,
                              input logic [15:0] value);
    send_item(req, addr, value, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_reply_byte(input logic [7:0] b, input logic first);
    send_item(REQ_RX, 16'($urandom), 16'($urandom), b, first);
  endtask

  task automatic send_reply_frame(input int len, input bit marked);
    for (int i = 0; i < len; i++) begin
      send_reply_byte(8'($urandom), marked && i == 0);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_beats.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_slave(input logic [7:0] addr);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= addr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    m_slave    = addr;
  endtask

  // Count from zero after reset even without a start mark.
  task automatic test_reply_after_reset();
    send_reply_byte(8'h11, 1'b0);
    send_reply_byte(8'h03, 1'b0);
    send_reply_byte(8'h02, 1'b0);
    send_reply_byte(8'hC3, 1'b0);
    send_reply_byte(8'h5A, 1'b0);
  endtask

  task automatic test_requests();
    send_request(REQ_READ, 16'h0000, 16'($urandom));
    send_request(REQ_WRITE, 16'hFFFF, 16'h8000);
    send_request(REQ_WRITE, 16'h00FF, 16'h7FFF);
    send_item(REQ_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom), 1'b1);
  endtask

  task automatic test_read_reply();
    send_request(REQ_READ, 16'hFFFF, 16'($urandom));
    send_reply_byte(8'($urandom), 1'b1);
    send_reply_byte(FUNC_READ, 1'b0);
    send_reply_byte(8'h02, 1'b0);
    send_reply_byte(8'hFF, 1'b0);
    send_reply_byte(8'hFF, 1'b0);
  endtask

  // Overlong write echo: only one value comes out of the frame.
  task automatic test_write_reply_long();
    send_request(REQ_WRITE, 16'h5A5A, 16'($urandom));
    send_reply_byte(8'h00, 1'b1);
    send_reply_byte(FUNC_WRITE, 1'b0);
    send_reply_byte(8'h5A, 1'b0);
    send_reply_byte(8'h5A, 1'b0);
    send_reply_byte(8'h7F, 1'b0);
    send_reply_byte(8'h00, 1'b0);
    send_reply_frame(4, 1'b0);
  endtask

  // Stall the output long enough to fill the block and stall its input.
  task automatic test_output_backpressure();
    hold_reqs++;
    for (int i = 0; i < 6; i++) begin
      send_request($urandom_range(1) ? REQ_WRITE : REQ_READ, 16'($urandom),
                   16'($urandom));
    end
  endtask

  task automatic test_random_traffic(input int n_items);
    int  sent;
    int  pick;
    int  len;
    int  cut;
    bit  is_wr;
    bit  mark;
    logic [1:0] req;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        is_wr = $urandom_range(1);
        send_request(is_wr ? REQ_WRITE : REQ_READ, 16'($urandom), 16'($urandom));
        send_reply_frame(is_wr ? 8 : 7, 1'b1);
        sent += is_wr ? 9 : 8;
      end else if (pick < 75) begin
        // broken reply: random length, maybe unmarked, maybe cut by a request
        len  = $urandom_range(10, 1);
        mark = $urandom_range(99) < 70;
        cut  = $urandom_range(len);
        send_reply_frame(cut, mark);
        if ($urandom_range(1)) begin
          send_request($urandom_range(1) ? REQ_WRITE : REQ_READ, 16'($urandom),
                       16'($urandom));
          sent++;
        end
        send_reply_frame(len - cut, mark && cut == 0);
        sent += len;
      end else if (pick < 90) begin
        send_request($urandom_range(1) ? REQ_WRITE : REQ_READ, 16'($urandom),
                     16'($urandom));
        sent++;
      end else begin
        req = 2'($urandom_range(3));
        send_item(req, 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
        if (req != REQ_UNUSED) begin
          sent++;
        end
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_beats.size() == 0) begin
        $error("unexpected beat: kind %0d tx %02h value %04h",
               out_kind, tx_byte, reply_value);
        n_errors++;
      end else begin
        want = due_beats.pop_front();
        check_field("out_kind", want.kind, out_kind);
        check_field("tx_byte", want.tx, tx_byte);
        check_field("tx_last", want.last, tx_last);
        check_field("reply_addr", want.addr, reply_addr);
        check_field("reply_value", want.value, reply_value);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 30);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck = 0;
    end else begin
      stuck++;
    end
    if (stuck >= STUCK_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reply_after_reset();
    test_requests();
    wait_idle();
    write_slave(8'd247);
    test_read_reply();
    wait_idle();
    write_slave(8'd0);
    test_write_reply_long();
    wait_idle();
    write_slave(8'd255);
    test_random_traffic(30);
    wait_idle();
    write_slave(8'($urandom));
    calm = 1'b1;
    test_random_traffic(30);
    wait_idle();
    calm = 1'b0;
    write_slave(8'($urandom_range(247)));
    test_output_backpressure();
    wait_idle();
    write_slave(8'($urandom));
    test_random_traffic(30);
    wait_idle();
    write_slave(8'($urandom_range(247)));
    test_random_traffic(30);
    wait_idle();
    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
